// ----- src/qpst_pkg.sv -----
// ----------------------------------------------------------------------------
// qpst_pkg
// Shared types and constants for the quadratic-probe symbol table.
// ----------------------------------------------------------------------------
package qpst_pkg;

	localparam int MAX_SLOTS = 256;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int NAME_W    = 32;
	localparam int TYPE_W    = 3;
	localparam int SIZE_W    = 9;
	localparam int ENTRY_W   = NAME_W + TYPE_W;
	localparam int BYTE_W    = 8;
	localparam int NBYTES    = NAME_W / BYTE_W;
	localparam int HASH_MUL  = 52;

	// remainder unit: bits retired per cycle and resulting number of steps
	localparam int REM_BITS  = 4;
	localparam int REM_STEPS = NAME_W / REM_BITS;
	localparam int REM_CNT_W = $clog2(REM_STEPS);

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_INSERTED  = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_FIRST,
		S_PROBE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] rem;
	} rem_stat_t;

	// zero every byte from the first zero byte on
	function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] res;
		logic              alive;
		res   = '0;
		alive = 1'b1;
		for (int k = 0; k < NBYTES; k++) begin
			if (raw[NAME_W-1-BYTE_W*k -: BYTE_W] == '0) alive = 1'b0;
			if (alive) res[NAME_W-1-BYTE_W*k -: BYTE_W] = raw[NAME_W-1-BYTE_W*k -: BYTE_W];
		end
		return res;
	endfunction

endpackage

// ----- src/qpst_ram.sv -----
// ----------------------------------------------------------------------------
// qpst_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qpst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- src/qpst_rem.sv -----
// ----------------------------------------------------------------------------
// qpst_rem
// Iterative remainder of the 32-bit hash by the table size, several bits a cycle.
// ----------------------------------------------------------------------------
module qpst_rem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [qpst_pkg::NAME_W-1:0] dividend,
	input  logic [qpst_pkg::SIZE_W-1:0] divisor,
	output qpst_pkg::rem_stat_t        stat
);
	import qpst_pkg::*;

	logic [NAME_W-1:0]    quo_q;
	logic [SLOT_W-1:0]    r_q;
	logic [SLOT_W-1:0]    r_nxt;
	logic [REM_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// restoring steps; remainder stays below divisor so one subtract per bit
	always_comb begin
		logic [SLOT_W:0] t;
		r_nxt = r_q;
		for (int k = 0; k < REM_BITS; k++) begin
			t = {r_nxt, quo_q[NAME_W-1-k]};
			if (t >= divisor) t = t - divisor;
			r_nxt = t[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == REM_CNT_W'(REM_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			r_q   <= '0;
		end else if (busy_q) begin
			quo_q <= quo_q << REM_BITS;
			r_q   <= r_nxt;
		end
	end

	assign stat = '{done: done_q, rem: r_q};

endmodule

// ----- src/quadratic_probe_symbol_table.sv -----
// ----------------------------------------------------------------------------
// quadratic_probe_symbol_table
// Open-addressing symbol table with quadratic probing over an entry RAM.
// ----------------------------------------------------------------------------
//  channel | signals                                      | transfer
//  in      | in_valid/in_ready, op, name, entry_type      | valid & ready
//  out     | out_valid/out_ready, status, slot, slot_type | valid & ready
//  cfg     | cfg_we, cfg_data (table_size)                | cfg_we
//
// One request at a time: an accept state, a hash state that takes the name one
// byte at a time, the remainder unit (8 steps, then done), a first RAM read,
// then one probe at a time, and a done state that hands over the result.
// A table_size of zero skips straight to the result.
// Reset clears the per-slot valid flops at once; no clearing pass.
// A new request is taken while an earlier result still waits on out_ready.
// ----------------------------------------------------------------------------
module quadratic_probe_symbol_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [qpst_pkg::NAME_W-1:0]  name,
	input  logic [qpst_pkg::TYPE_W-1:0]  entry_type,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [qpst_pkg::SLOT_W-1:0]  slot,
	output logic [qpst_pkg::TYPE_W-1:0]  slot_type,
	input  logic                         cfg_we,
	input  logic [qpst_pkg::SIZE_W-1:0]  cfg_data
);
	import qpst_pkg::*;

	state_t state_q, state_nxt;

	logic [SIZE_W-1:0]    table_size_q;
	logic [SIZE_W-1:0]    sz_q;
	logic [SIZE_W-1:0]    sz_in;
	logic                 ins_in;
	logic                 ins_q;
	logic [NAME_W-1:0]    nm_q;
	logic [TYPE_W-1:0]    ty_q;
	logic [NAME_W-1:0]    h_q;
	logic [NAME_W-1:0]    h_nxt;
	logic [1:0]           hcnt_q;
	logic [BYTE_W-1:0]    hbyte;

	logic [SLOT_W-1:0]    s_q;
	logic [SLOT_W-1:0]    d_q;
	logic [SLOT_W-1:0]    s_nxt;
	logic [SLOT_W-1:0]    d_nxt;
	logic [SIZE_W:0]      sum_s;
	logic [SIZE_W:0]      sum_d;
	logic [SIZE_W-1:0]    left_q;
	logic [SLOT_W-1:0]    chk_s1;
	logic                 vld_s1;
	logic [MAX_SLOTS-1:0] vld_q;

	logic                 seen_q;
	logic [SLOT_W-1:0]    last_slot_q;
	logic [TYPE_W-1:0]    last_type_q;

	logic [ENTRY_W-1:0]   rdata;
	logic [NAME_W-1:0]    rd_name;
	logic [TYPE_W-1:0]    rd_type;

	logic                 empty;
	logic                 match;
	logic                 stop;
	status_t              res_st;
	logic [SLOT_W-1:0]    res_slot;
	logic [TYPE_W-1:0]    res_type;

	status_t              pst_q;
	logic [SLOT_W-1:0]    pslot_q;
	logic [TYPE_W-1:0]    ptype_q;

	status_t              ost_q;
	logic [SLOT_W-1:0]    oslot_q;
	logic [TYPE_W-1:0]    otype_q;
	logic                 out_valid_q;
	logic                 out_free;

	logic                 accept;
	logic                 rem_start;
	logic                 adv;
	logic                 ram_we;
	logic                 out_load;
	rem_stat_t            rem_stat;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) table_size_q <= SIZE_W'(MAX_SLOTS);
		else if (cfg_we) table_size_q <= cfg_data;
	end

	assign sz_in  = (table_size_q > SIZE_W'(MAX_SLOTS)) ? SIZE_W'(MAX_SLOTS) : table_size_q;
	assign ins_in = op && (entry_type != '0);

	// ---------------- hash: one byte per cycle ----------------
	assign hbyte = nm_q[{~hcnt_q, 3'b000} +: BYTE_W];
	// h*52 as shifts; a zero byte ends the name, so h stops changing
	assign h_nxt = (hbyte == '0) ? h_q
	             : (h_q << 5) + (h_q << 4) + (h_q << 2) + NAME_W'(hbyte);

	// ---------------- probe sequence ----------------
	// slot advances by an odd step (2i+1) mod size, step grows by 2
	assign sum_s = {2'b00, s_q} + {2'b00, d_q};
	assign sum_d = {2'b00, d_q} + (SIZE_W+1)'(2);
	assign s_nxt = (sum_s >= {1'b0, sz_q}) ? SLOT_W'(sum_s - {1'b0, sz_q}) : SLOT_W'(sum_s);
	assign d_nxt = (sum_d >= {1'b0, sz_q}) ? SLOT_W'(sum_d - {1'b0, sz_q}) : SLOT_W'(sum_d);

	qpst_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (h_nxt),
		.divisor  (sz_q),
		.stat     (rem_stat)
	);

	qpst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (chk_s1),
		.wdata ({nm_q, ty_q}),
		.raddr (s_q),
		.rdata (rdata)
	);

	assign rd_name = rdata[ENTRY_W-1:TYPE_W];
	assign rd_type = rdata[TYPE_W-1:0];

	// ---------------- probe decision ----------------
	assign empty = !vld_s1;
	assign match = vld_s1 && (rd_name == nm_q);
	assign stop  = empty || (match && !ins_q) || (left_q == SIZE_W'(1));

	always_comb begin
		res_st   = ins_q ? ST_FULL : ST_NOT_FOUND;
		res_slot = '0;
		res_type = '0;
		if (empty) begin
			if (!ins_q) begin
				res_st = ST_NOT_FOUND;
			end else if (seen_q) begin
				res_st   = ST_FOUND;
				res_slot = last_slot_q;
				res_type = last_type_q;
			end else begin
				res_st   = ST_INSERTED;
				res_slot = chk_s1;
				res_type = ty_q;
			end
		end else if (match && !ins_q) begin
			res_st   = ST_FOUND;
			res_slot = chk_s1;
			res_type = rd_type;
		end
	end

	// ---------------- control ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_nxt = (sz_in == '0) ? S_DONE : S_HASH;
			S_HASH:  if (hcnt_q == 2'd3) state_nxt = S_MOD;
			S_MOD:   if (rem_stat.done) state_nxt = S_FIRST;
			S_FIRST: state_nxt = S_PROBE;
			S_PROBE: if (stop) state_nxt = S_DONE;
			S_DONE:  if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		in_ready  = 1'b0;
		rem_start = 1'b0;
		adv       = 1'b0;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_HASH:  rem_start = (hcnt_q == 2'd3);
			S_MOD:   ;
			S_FIRST: adv = 1'b1;
			S_PROBE: begin
				adv    = 1'b1;
				ram_we = empty && ins_q && !seen_q;
			end
			S_DONE:  out_load = out_free;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ram_we) vld_q[chk_s1] <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			nm_q   <= canon_name(name);
			ty_q   <= entry_type;
			ins_q  <= ins_in;
			sz_q   <= sz_in;
			h_q    <= '0;
			hcnt_q <= '0;
			// empty table: no probes at all
			pst_q   <= ins_in ? ST_FULL : ST_NOT_FOUND;
			pslot_q <= '0;
			ptype_q <= '0;
		end
		if (state_q == S_HASH) begin
			h_q    <= h_nxt;
			hcnt_q <= hcnt_q + 2'd1;
		end
		if (state_q == S_MOD && rem_stat.done) begin
			s_q    <= rem_stat.rem;
			d_q    <= (sz_q == SIZE_W'(1)) ? '0 : SLOT_W'(1);
			left_q <= sz_q;
			seen_q <= 1'b0;
		end
		if (adv) begin
			s_q    <= s_nxt;
			d_q    <= d_nxt;
			chk_s1 <= s_q;
			vld_s1 <= vld_q[s_q];
		end
		if (state_q == S_PROBE) begin
			left_q <= left_q - SIZE_W'(1);
			if (match && ins_q) begin
				seen_q      <= 1'b1;
				last_slot_q <= chk_s1;
				last_type_q <= rd_type;
			end
			if (stop) begin
				pst_q   <= res_st;
				pslot_q <= res_slot;
				ptype_q <= res_type;
			end
		end
		if (out_load) begin
			ost_q   <= pst_q;
			oslot_q <= pslot_q;
			otype_q <= ptype_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = ost_q;
	assign slot      = oslot_q;
	assign slot_type = otype_q;

endmodule

// ----- src/qpst_checker.sv -----
// ----------------------------------------------------------------------------
// qpst_checker
// Port-level assertions for the quadratic-probe symbol table.
// ----------------------------------------------------------------------------
module qpst_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   status,
	input logic [qpst_pkg::SLOT_W-1:0]  slot,
	input logic [qpst_pkg::TYPE_W-1:0]  slot_type
);
	import qpst_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot)
		&& $stable(slot_type))
		else $error("result changed while stalled");

	// no entry behind a miss or a full table
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_FOUND || status == ST_FULL)
		|-> slot == '0 && slot_type == '0)
		else $error("miss carries slot or type");

	// a hit or insert always names an occupied slot
	a_hit_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FOUND || status == ST_INSERTED) |-> slot_type != '0)
		else $error("hit with empty type");

	// one request at a time, and no result in the cycle right after accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !$rose(out_valid))
		else $error("request overlap");

endmodule

bind quadratic_probe_symbol_table qpst_checker u_qpst_checker (.*);

// ----- sim/qpst_answer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpst_answer_checker
// Watches the request, answer and size-write ports of the symbol table. Keeps
// its own copy of the slot store and the table size, works out the answer of
// every accepted request and compares each accepted answer, in order.
// ----------------------------------------------------------------------------
module qpst_answer_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         op,
	input  logic [qpst_pkg::NAME_W-1:0]  name,
	input  logic [qpst_pkg::TYPE_W-1:0]  entry_type,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [1:0]                   status,
	input  logic [qpst_pkg::SLOT_W-1:0]  slot,
	input  logic [qpst_pkg::TYPE_W-1:0]  slot_type,
	input  logic                         cfg_we,
	input  logic [qpst_pkg::SIZE_W-1:0]  cfg_data,
	output int                           bad_answers,
	output int                           answers_due
);
	import qpst_pkg::*;

	typedef struct packed {
		status_t             st;
		logic [SLOT_W-1:0]   slot;
		logic [TYPE_W-1:0]   kind;
	} answer_t;

	logic [NAME_W-1:0] store_name [MAX_SLOTS];
	logic [TYPE_W-1:0] store_kind [MAX_SLOTS];
	logic [SIZE_W-1:0] size_now;
	answer_t           due_answers [$];
	int                errs;

	// one request against the local store; claims a slot on a successful insert
	function automatic answer_t probe_table(input logic is_insert,
		input logic [NAME_W-1:0] raw, input logic [TYPE_W-1:0] kind);
		answer_t           res;
		logic [NAME_W-1:0] key;
		logic [31:0]       h;
		logic [BYTE_W-1:0] b;
		logic              alive;
		logic              claiming;
		logic              seen;
		logic              stop;
		logic [63:0]       pos;
		int                span;
		int                idx;
		int                hit;
		int                last_hit;
		int                k;
		int                i;
		key   = '0;
		h     = '0;
		alive = 1'b1;
		for (k = 0; k < NBYTES; k++) begin
			b = raw[NAME_W-1-BYTE_W*k -: BYTE_W];
			if (b == '0) alive = 1'b0;
			if (alive) begin
				key[NAME_W-1-BYTE_W*k -: BYTE_W] = b;
				h = h * HASH_MUL + b;
			end
		end
		// an insert of type zero behaves as a lookup
		claiming = is_insert && (kind != '0);
		span     = (size_now > MAX_SLOTS) ? MAX_SLOTS : int'(size_now);
		res.st   = claiming ? ST_FULL : ST_NOT_FOUND;
		res.slot = '0;
		res.kind = '0;
		seen     = 1'b0;
		stop     = 1'b0;
		hit      = 0;
		last_hit = 0;
		for (i = 0; i < span && !stop; i++) begin
			pos = {32'd0, h} + 64'(i * i);
			idx = int'(pos % 64'(span));
			if (store_kind[idx] == '0) begin
				stop = 1'b1;
				if (!claiming) begin
					res.st = ST_NOT_FOUND;
				end else if (seen) begin
					res.st = ST_FOUND;
					hit    = last_hit;
				end else begin
					store_name[idx] = key;
					store_kind[idx] = kind;
					res.st          = ST_INSERTED;
					hit             = idx;
				end
			end else if (store_name[idx] == key) begin
				if (!claiming) begin
					res.st = ST_FOUND;
					hit    = idx;
					stop   = 1'b1;
				end else begin
					seen     = 1'b1;
					last_hit = idx;
				end
			end
		end
		if (res.st == ST_FOUND || res.st == ST_INSERTED) begin
			res.slot = hit[SLOT_W-1:0];
			res.kind = store_kind[hit];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLOTS; s++) begin
				store_name[s] = '0;
				store_kind[s] = '0;
			end
			size_now = SIZE_W'(MAX_SLOTS);
			due_answers.delete();
			errs = 0;
		end else begin
			if (out_valid && out_ready) begin
				got.st   = status_t'(status);
				got.slot = slot;
				got.kind = slot_type;
				if (due_answers.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: answer with no request waiting: status %0d slot %0d type %0d",
							$realtime, status, slot, slot_type);
				end else begin
					want = due_answers.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10) begin
							$display("%0t: answer mismatch: expected status %0d slot %0d type %0d,",
								$realtime, want.st, want.slot, want.kind);
							$display("    got status %0d slot %0d type %0d",
								status, slot, slot_type);
						end
					end
				end
			end
			// a request taken at this edge still sees the old size
			if (in_valid && in_ready) due_answers.push_back(probe_table(op, name, entry_type));
			if (cfg_we) size_now = cfg_data;
		end
		bad_answers <= errs;
		answers_due <= due_answers.size();
	end

endmodule

// ----- sim/tb_quadratic_probe_symbol_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_probe_symbol_table
// Drives lookups and inserts into the symbol table over a range of table
// sizes, with random gaps, answer back-pressure and one long answer stall.
// A checker beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_symbol_table;
	import qpst_pkg::*;

	localparam logic OP_LOOKUP   = 1'b0;
	localparam logic OP_INSERT   = 1'b1;
	localparam int   POOL_N      = 40;
	localparam int   PHASE_N     = 17;
	localparam int   PHASE_ITEMS = 88;
	localparam int   LONG_HOLD   = 400;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                op;
	logic [NAME_W-1:0]   name;
	logic [TYPE_W-1:0]   entry_type;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          status;
	logic [SLOT_W-1:0]   slot;
	logic [TYPE_W-1:0]   slot_type;
	logic                cfg_we;
	logic [SIZE_W-1:0]   cfg_data;

	logic                idling       = 1'b0;
	int                  hold_ticket  = 0;
	int                  holds_served = 0;
	int unsigned         ready_hold   = 0;
	int                  bad_answers;
	int                  answers_due;
	logic [NAME_W-1:0]   name_pool [POOL_N];
	int                  size_plan [PHASE_N] = '{3, 1, 5, 2, 8, 13, 0, 31, 64, 7, 100, 256, 17,
		511, 200, 4, 64};

	quadratic_probe_symbol_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.name       (name),
		.entry_type (entry_type),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.slot_type  (slot_type),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	qpst_answer_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.name        (name),
		.entry_type  (entry_type),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.slot        (slot),
		.slot_type   (slot_type),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.bad_answers (bad_answers),
		.answers_due (answers_due)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// answer side: random stall bursts, plus one long hold when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready    <= 1'b0;
			ready_hold   <= 0;
			holds_served <= 0;
		end else if (holds_served != hold_ticket) begin
			out_ready    <= 1'b0;
			ready_hold   <= LONG_HOLD;
			holds_served <= hold_ticket;
		end else if (ready_hold != 0) begin
			out_ready  <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			ready_hold <= $urandom_range(0, 8);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// returns at the edge where the request is taken
	task automatic offer_request(input logic o, input logic [NAME_W-1:0] nm,
		input logic [TYPE_W-1:0] ty);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		name       <= nm;
		entry_type <= ty;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic settle_answers();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_table_size(input logic [SIZE_W-1:0] sz);
		settle_answers();
		cfg_we   <= 1'b1;
		cfg_data <= sz;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_request();
		logic [NAME_W-1:0] nm;
		logic              past_zero;
		int                pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			nm = name_pool[$urandom_range(0, POOL_N-1)];
			// junk after the terminating zero must not change the name
			if ($urandom_range(0, 2) == 0) begin
				past_zero = 1'b0;
				for (int k = 0; k < NBYTES; k++) begin
					if (past_zero) nm[NAME_W-1-BYTE_W*k -: BYTE_W] = BYTE_W'($urandom());
					else if (nm[NAME_W-1-BYTE_W*k -: BYTE_W] == '0) past_zero = 1'b1;
				end
			end
		end else if (pick < 9) begin
			nm = $urandom();
		end else begin
			nm = {8'h00, 24'($urandom())};
		end
		offer_request($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, nm,
			TYPE_W'($urandom_range(0, 7)));
	endtask

	initial begin
		logic [NAME_W-1:0] nm;
		int                len;
		in_valid   = 1'b0;
		op         = OP_LOOKUP;
		name       = '0;
		entry_type = '0;
		cfg_we     = 1'b0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		for (int p = 0; p < POOL_N; p++) begin
			len = $urandom_range(0, NBYTES);
			nm  = '0;
			for (int k = 0; k < len; k++)
				nm[NAME_W-1-BYTE_W*k -: BYTE_W] = BYTE_W'($urandom_range(1, 255));
			name_pool[p] = nm;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full-size table straight out of reset
		offer_request(OP_LOOKUP, 32'h0000_0000, 3'd0);
		offer_request(OP_INSERT, 32'h4100_0000, 3'd7);
		offer_request(OP_INSERT, 32'h4100_0000, 3'd3);
		offer_request(OP_LOOKUP, 32'h4100_BEEF, 3'd0);
		offer_request(OP_INSERT, 32'h4200_0000, 3'd0);
		offer_request(OP_INSERT, 32'hFFFF_FFFF, 3'd1);
		offer_request(OP_LOOKUP, 32'hFFFF_FFFF, 3'd7);
		offer_request(OP_INSERT, 32'h00AB_CDEF, 3'd5);
		offer_request(OP_LOOKUP, 32'h0000_0000, 3'd2);
		offer_request(OP_INSERT, 32'h4142_4344, 3'd6);
		// no slots at all
		set_table_size('0);
		offer_request(OP_LOOKUP, 32'h4100_0000, 3'd0);
		offer_request(OP_INSERT, 32'h5100_0000, 3'd4);
		// single slot, already held by the empty name: probes run out
		set_table_size(9'd1);
		offer_request(OP_INSERT, 32'h5A00_0000, 3'd2);
		offer_request(OP_INSERT, 32'h0000_0000, 3'd4);
		offer_request(OP_LOOKUP, 32'h0012_3456, 3'd0);
		offer_request(OP_LOOKUP, 32'h4100_0000, 3'd0);
		// oversize register clamps to the full table
		set_table_size('1);
		offer_request(OP_LOOKUP, 32'h4100_0000, 3'd0);
		offer_request(OP_INSERT, 32'h7F7F_7F7F, 3'd6);
		offer_request(OP_LOOKUP, 32'h8080_8080, 3'd0);

		for (int p = 0; p < PHASE_N; p++) begin
			set_table_size(SIZE_W'(size_plan[p]));
			idling <= (p % 4 != 2) && (p != PHASE_N-1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == 20) hold_ticket <= hold_ticket + 1;
				random_request();
			end
		end

		settle_answers();
		repeat (16) @(posedge clk);
		if (bad_answers == 0 && answers_due == 0)
			$display("quadratic_probe_symbol_table regression: pass");
		else
			$display("quadratic_probe_symbol_table regression: fail");
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("quadratic_probe_symbol_table regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
src/qpst_pkg.sv
src/qpst_ram.sv
src/qpst_rem.sv
src/quadratic_probe_symbol_table.sv
src/qpst_checker.sv
sim/qpst_answer_checker.sv
sim/tb_quadratic_probe_symbol_table.sv
